[rtl/wmd_pkg.sv]
`default_nettype none

package wmd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int MAX_CHUNKS   = 4096;

  // Reciprocal scale: mean = (|sum| * recip) >> RECIP_SHIFT, exact for |sum| < 2^19
  localparam int SUM_W       = 20;
  localparam int MAG_W       = 19;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = MAG_W + RECIP_W;

  localparam int CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT    = 2'd0,
    CFG_FRAMES_PER_CHUNK = 2'd1,
    CFG_CHUNK_COUNT      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic signed [15:0] sample_4;
    logic signed [15:0] sample_5;
    logic signed [15:0] sample_6;
    logic signed [15:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic        [11:0] chunk_index;
    logic signed [15:0] min_amp;
    logic        [14:0] max_amp;
    logic               last_chunk;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [23:0] frames_per_chunk;
    logic [12:0] chunk_count;
  } cfg_t;

  // Frame sum in sign/magnitude form, handed from front to back
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sum_item_t;

  function automatic logic [3:0] eff_channels(input logic [3:0] c);
    logic [3:0] r;
    r = c;
    if (c == 4'd0) r = 4'd1;
    if (c > 4'(MAX_CHANNELS)) r = 4'(MAX_CHANNELS);
    return r;
  endfunction

  function automatic logic [23:0] eff_fpc(input logic [23:0] f);
    return (f == 24'd0) ? 24'd1 : f;
  endfunction

  function automatic logic [12:0] eff_chunks(input logic [12:0] n);
    return (n > 13'(MAX_CHUNKS)) ? 13'(MAX_CHUNKS) : n;
  endfunction

  // ceil(2^22 / c) for c = 1..8
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] c);
    logic [RECIP_W-1:0] r;
    unique case (c)
      4'd1:    r = 23'd4194304;
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/wmd_front.sv]
`default_nettype none

module wmd_front (
  input  wire  logic               in_valid,
  output logic                     in_stall,
  input  wire  wmd_pkg::in_item_t  in_data,
  input  wire  wmd_pkg::cfg_t      cfg,
  input  wire  logic               q_full,
  output logic                     q_push,
  output wmd_pkg::sum_item_t       q_data
);
  import wmd_pkg::*;

  logic signed [15:0]      smp   [MAX_CHANNELS];
  logic signed [SUM_W-1:0] term  [MAX_CHANNELS];
  logic signed [SUM_W-1:0] l1    [4];
  logic signed [SUM_W-1:0] l2    [2];
  logic signed [SUM_W-1:0] sum;
  logic        [3:0]       chans;

  assign smp[0] = in_data.sample_0;
  assign smp[1] = in_data.sample_1;
  assign smp[2] = in_data.sample_2;
  assign smp[3] = in_data.sample_3;
  assign smp[4] = in_data.sample_4;
  assign smp[5] = in_data.sample_5;
  assign smp[6] = in_data.sample_6;
  assign smp[7] = in_data.sample_7;

  assign chans = eff_channels(cfg.channel_count);

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      term[i] = (4'(i) < chans) ? SUM_W'(smp[i]) : '0;
    end
    for (int i = 0; i < 4; i++) begin
      l1[i] = term[2*i] + term[2*i+1];
    end
    l2[0] = l1[0] + l1[1];
    l2[1] = l1[2] + l1[3];
    sum   = l2[0] + l2[1];
  end

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign q_data.neg = sum[SUM_W-1];
  assign q_data.mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

endmodule

`default_nettype wire

[rtl/wmd_queue.sv]
`default_nettype none

module wmd_queue (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                push,
  input  wire  wmd_pkg::sum_item_t  push_data,
  output logic                      full,
  input  wire  logic                pop,
  output logic                      valid,
  output wmd_pkg::sum_item_t        pop_data
);
  import wmd_pkg::*;

  sum_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/wmd_back.sv]
`default_nettype none

module wmd_back (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  wmd_pkg::cfg_t       cfg,
  input  wire  logic                q_valid,
  input  wire  wmd_pkg::sum_item_t  q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire  logic                out_stall,
  output wmd_pkg::out_item_t        out_data
);
  import wmd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FOLD = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [PROD_W-1:0]     prod_r;
  logic                  neg_r;
  logic [23:0]           fic_r, fic_nxt;
  logic [12:0]           cur_r, cur_nxt;
  logic signed [15:0]    min_r, min_nxt;
  logic [14:0]           max_r, max_nxt;
  logic                  done_r, done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [3:0]            chans;
  logic [23:0]           fpc;
  logic [12:0]           chunks;
  logic                  advance;
  logic [15:0]           quo;
  logic signed [16:0]    mean;
  logic signed [15:0]    new_min;
  logic [14:0]           new_max;
  logic [23:0]           fic_inc;
  logic [12:0]           cur_inc;
  logic                  complete;

  assign chans  = eff_channels(cfg.channel_count);
  assign fpc    = eff_fpc(cfg.frames_per_chunk);
  assign chunks = eff_chunks(cfg.chunk_count);

  // fold step may retire only when the output register can take a result
  assign advance = (state_r == S_FOLD) && !(out_valid_r && out_stall);
  assign q_pop   = q_valid && ((state_r == S_IDLE) || advance);

  assign quo  = prod_r[RECIP_SHIFT+15:RECIP_SHIFT];
  assign mean = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    new_min  = (mean < 17'(min_r)) ? mean[15:0] : min_r;
    new_max  = (mean > $signed({2'b00, max_r})) ? mean[14:0] : max_r;
    fic_inc  = fic_r + 24'd1;
    cur_inc  = cur_r + 13'd1;
    complete = (fic_inc == 24'd0) || (fic_inc >= fpc);
  end

  always_comb begin
    state_nxt     = state_r;
    fic_nxt       = fic_r;
    cur_nxt       = cur_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (advance) begin
      if (done_r || (cur_r >= chunks)) begin
        done_nxt = 1'b1;
      end else if (complete) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.chunk_index = cur_r[11:0];
        out_data_nxt.min_amp     = new_min;
        out_data_nxt.max_amp     = new_max;
        out_data_nxt.last_chunk  = (cur_r == chunks - 13'd1);
        fic_nxt                  = '0;
        min_nxt                  = '0;
        max_nxt                  = '0;
        cur_nxt                  = cur_inc;
        if (cur_inc >= chunks) begin
          done_nxt = 1'b1;
        end
      end else begin
        fic_nxt = fic_inc;
        min_nxt = new_min;
        max_nxt = new_max;
      end
    end

    priority if (q_pop) begin
      state_nxt = S_FOLD;
    end else if (advance) begin
      state_nxt = S_IDLE;
    end else begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fic_r       <= '0;
      cur_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fic_r       <= fic_nxt;
      cur_r       <= cur_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_pop) begin
      prod_r <= PROD_W'(q_data.mag) * PROD_W'(recip(chans));
      neg_r  <= q_data.neg;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/waveform_minmax_decimator_core.sv]
// Min/max envelope decimator. Each request on the in_ channel is one audio frame of up to
// eight signed Q15 samples; the first channel_count are averaged (sum / count, truncated
// toward zero) and the block tracks the min (<= 0) and max (>= 0) of that mean over every
// chunk of frames_per_chunk frames. Each finished chunk gives one out_ request with its
// index, the pair and a last-chunk flag; frames after chunk_count chunks are swallowed.
// One frame per clock unless out_stall holds the output: the front adds the samples and pushes
// the sum into a two-entry queue, the back multiplies by a reciprocal in one stage and folds
// the result in the next. A closing frame's sum passes the queue and prod_r to out_data_r.
// in_stall rises only when the queue is full, which happens when the output
// register is held by out_stall. Registers are written through cfg_ (index 0 channel_count,
// 1 frames_per_chunk, 2 chunk_count) and should only be changed while the block is idle.
`default_nettype none

module waveform_minmax_decimator_core (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  // frame input
  input  wire  logic                in_valid,
  output logic                      in_stall,
  input  wire  wmd_pkg::in_item_t   in_data,
  // chunk results
  output logic                      out_valid,
  input  wire  logic                out_stall,
  output wmd_pkg::out_item_t        out_data,
  // register writes
  input  wire  logic                cfg_valid,
  output logic                      cfg_ready,
  input  wire  logic [1:0]          cfg_index,
  input  wire  logic [23:0]         cfg_data
);
  import wmd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       q_full, q_push, q_pop, q_valid;
  sum_item_t  push_data, pop_data;

  // Config registers: always ready, writes are registered into cfg_r.
  // Index 3 is outside the register map and is dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHANNEL_COUNT:    cfg_nxt.channel_count    = cfg_data[3:0];
        CFG_FRAMES_PER_CHUNK: cfg_nxt.frames_per_chunk = cfg_data[23:0];
        CFG_CHUNK_COUNT:      cfg_nxt.chunk_count      = cfg_data[12:0];
        default:              cfg_nxt                  = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count    <= 4'd2;
      cfg_r.frames_per_chunk <= 24'd1;
      cfg_r.chunk_count      <= 13'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: channel masking and adder tree, result in sign/magnitude
  wmd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // Two-entry decoupling queue
  wmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  // Back: reciprocal divide, min/max fold, chunk counting, output register
  wmd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[dv/waveform_minmax_decimator_core_tb.sv]
`timescale 1ns / 1ps

module waveform_minmax_decimator_core_tb;
  import wmd_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 9;
  // A closing frame passes the queue and prod_r before out_valid rises. Frames closing no
  // chunk leave nothing to wait on, so give the pipe a few extra cycles.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_FRAMES = 1550;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;

  waveform_minmax_decimator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Shadow of the register file, updated when a write request is taken.
  logic [3:0]  sh_channels = 4'd2;
  logic [23:0] sh_fpc      = 24'd1;
  logic [12:0] sh_chunks   = 13'd1024;

  // Envelope state as the block should hold it.
  logic [23:0] env_frames = '0;
  logic [12:0] env_chunk  = '0;
  int          env_min    = 0;
  int          env_max    = 0;
  logic        env_done   = 1'b0;

  in_item_t    frame_q[$];          // frames not yet put on the bus
  out_item_t   chunk_expect_q[$];   // min/max pairs still owed by the block
  int          frames_queued = 0;
  int          frames_taken  = 0;
  int          mismatches    = 0;

  // Per-side random idle draw after each request, bounded by a max that each phase sets.
  int          in_gap_max  = 0;
  int          out_gap_max = 0;
  int          in_gap      = 0;
  int          out_hold    = 0;
  out_item_t   want;

  // Fold one taken frame into the envelope; queue a pair when its chunk closes.
  function void fold_frame(input in_item_t f);
    logic signed [15:0] s [8];
    int        n, fpc, lim, acc, mean, i;
    out_item_t r;
    s = '{f.sample_0, f.sample_1, f.sample_2, f.sample_3,
          f.sample_4, f.sample_5, f.sample_6, f.sample_7};
    n   = (sh_channels == 0) ? 1 : ((sh_channels > MAX_CHANNELS) ? MAX_CHANNELS : sh_channels);
    fpc = (sh_fpc == 0) ? 1 : sh_fpc;
    lim = (sh_chunks > MAX_CHUNKS) ? MAX_CHUNKS : sh_chunks;
    // past the last chunk everything is dropped, and stays dropped
    if (env_done || env_chunk >= lim) begin
      env_done = 1'b1;
      return;
    end
    acc = 0;
    for (i = 0; i < n; i++) acc += s[i];
    mean = acc / n;   // truncates toward zero
    if (mean < env_min) env_min = mean;
    if (mean > env_max) env_max = mean;
    env_frames = env_frames + 24'd1;
    // count may already sit past a freshly lowered fpc: close on this frame
    if (env_frames != 0 && env_frames < fpc) return;
    r.chunk_index = env_chunk[11:0];
    r.min_amp     = env_min[15:0];
    r.max_amp     = env_max[14:0];
    r.last_chunk  = (env_chunk == lim - 1);
    chunk_expect_q.push_back(r);
    env_frames = '0;
    env_min    = 0;
    env_max    = 0;
    env_chunk  = env_chunk + 13'd1;
    if (env_chunk >= lim) env_done = 1'b1;
  endfunction

  // Frame driver: one request per slot, random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_frame(in_data);
        frames_taken++;
      end
      // payload is held while stalled
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (frame_q.size() != 0) begin
          in_data  <= frame_q.pop_front();
          in_valid <= 1'b1;
          in_gap = $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken pair with the oldest one owed, then stall a while.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (chunk_expect_q.size() == 0) begin
          $error("unexpected chunk result, chunk_index %0d", out_data.chunk_index);
          mismatches++;
        end else begin
          want = chunk_expect_q.pop_front();
          if (out_data.chunk_index !== want.chunk_index) begin
            $error("chunk_index: expected %0d, got %0d", want.chunk_index, out_data.chunk_index);
            mismatches++;
          end
          if (out_data.min_amp !== want.min_amp) begin
            $error("min_amp: expected %0d, got %0d", want.min_amp, out_data.min_amp);
            mismatches++;
          end
          if (out_data.max_amp !== want.max_amp) begin
            $error("max_amp: expected %0d, got %0d", want.max_amp, out_data.max_amp);
            mismatches++;
          end
          if (out_data.last_chunk !== want.last_chunk) begin
            $error("last_chunk: expected %0d, got %0d", want.last_chunk, out_data.last_chunk);
            mismatches++;
          end
        end
        out_hold = $urandom_range(0, out_gap_max);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHANNEL_COUNT:    sh_channels = val[3:0];
      CFG_FRAMES_PER_CHUNK: sh_fpc      = val;
      CFG_CHUNK_COUNT:      sh_chunks   = val[12:0];
      default: ;
    endcase
  endtask

  // Wait until every queued frame is taken and every owed pair has come back.
  task automatic settle();
    while (frames_taken != frames_queued || chunk_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_frame(input in_item_t f);
    frame_q.push_back(f);
    frames_queued++;
  endtask

  // Random frame shaped to hit the corners of the mean: equal channels, rails,
  // values around zero, near-equal clusters, or plain noise.
  function automatic in_item_t rand_frame();
    logic [15:0] s [8];
    logic [15:0] base;
    int          mode, i;
    base = 16'($urandom);
    mode = $urandom_range(0, 9);
    for (i = 0; i < 8; i++) begin
      case (mode)
        4: s[i] = base;
        5: begin
          case ($urandom_range(0, 4))
            0:       s[i] = 16'h8000;
            1:       s[i] = 16'h7fff;
            2:       s[i] = 16'h0000;
            3:       s[i] = 16'hffff;
            default: s[i] = 16'h0001;
          endcase
        end
        6: s[i] = 16'($urandom_range(0, 400) - 200);
        7: s[i] = base[0] ? 16'h8000 : 16'h7fff;
        8: s[i] = base + 16'($urandom_range(0, 63));
        default: s[i] = 16'($urandom);
      endcase
    end
    return {s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7]};
  endfunction

  function automatic in_item_t flat_frame(input logic [15:0] v);
    return {8{v}};
  endfunction

  // First two channels fixed, the rest noise that must not leak into the mean.
  function automatic in_item_t lead_frame(input logic [15:0] a, input logic [15:0] b);
    in_item_t f;
    f = rand_frame();
    f.sample_0 = a;
    f.sample_1 = b;
    return f;
  endfunction

  initial begin
    in_item_t f;
    int       sent, n, k, pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: reset setup is 2 channels, one frame per chunk ---
    push_frame(flat_frame(16'h7fff));           // max rail
    push_frame(flat_frame(16'h8000));           // min rail
    push_frame(flat_frame(16'h0000));
    push_frame(lead_frame(16'h7fff, 16'h8000)); // -1/2 rounds to 0
    push_frame(lead_frame(-16'sd3, 16'h0000));  // -3/2 -> -1
    push_frame(lead_frame(16'd3, 16'h0000));
    settle();

    // channel count zero behaves as one channel
    write_reg(CFG_CHANNEL_COUNT, 24'd0);
    push_frame(lead_frame(16'h8000, 16'd5));
    push_frame(lead_frame(16'd12345, 16'h8000));
    settle();

    // count above eight clamps to eight
    write_reg(CFG_CHANNEL_COUNT, 24'd15);
    push_frame(flat_frame(16'h8000));
    push_frame(flat_frame(16'h7fff));
    push_frame(rand_frame());
    settle();

    // odd divisor, negative truncation
    write_reg(CFG_CHANNEL_COUNT, 24'd3);
    f = lead_frame(-16'sd3, -16'sd2);
    f.sample_2 = 16'h0000;
    push_frame(f);
    f = lead_frame(16'h7fff, 16'h7fff);
    f.sample_2 = 16'h7ffe;
    push_frame(f);
    settle();

    // fpc zero acts as one
    write_reg(CFG_FRAMES_PER_CHUNK, 24'd0);
    push_frame(rand_frame());
    settle();

    // chunk count above the maximum clamps; three-frame chunk
    write_reg(CFG_FRAMES_PER_CHUNK, 24'd3);
    write_reg(CFG_CHUNK_COUNT, 24'd8191);
    push_frame(flat_frame(16'h1234));
    push_frame(flat_frame(16'hc000));
    push_frame(rand_frame());
    settle();

    // widest fpc leaves the chunk open; lowering it closes the chunk on the next frame
    write_reg(CFG_CHANNEL_COUNT, 24'd8);
    write_reg(CFG_FRAMES_PER_CHUNK, 24'hffffff);
    for (k = 0; k < 4; k++) push_frame(rand_frame());
    settle();
    write_reg(CFG_FRAMES_PER_CHUNK, 24'd2);
    push_frame(rand_frame());
    settle();

    // --- random phases ---
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      settle();
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0; out_gap_max = 0; end  // full rate
        1: begin in_gap_max = 4; out_gap_max = 0; end
        2: begin in_gap_max = 0; out_gap_max = 4; end  // backpressure fills the queue
        default: begin in_gap_max = 4; out_gap_max = 4; end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        write_reg(CFG_CHANNEL_COUNT, (pick == 0) ? 24'd0 : (pick == 1) ? 24'd15 :
                                     (pick == 2) ? 24'd8 : (pick == 3) ? 24'd1 :
                                     24'($urandom_range(1, 12)));
      end
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        write_reg(CFG_FRAMES_PER_CHUNK, (pick < 3) ? 24'd1 : (pick == 3) ? 24'd0 :
                                        (pick == 4) ? 24'($urandom_range(20, 60)) :
                                        24'($urandom_range(2, 8)));
      end
      // chunk count stays well above the number of pairs the run can produce
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 2);
        write_reg(CFG_CHUNK_COUNT, (pick == 0) ? 24'd4096 : (pick == 1) ? 24'd8191 :
                                   24'($urandom_range(3000, 8191)));
      end
      n = $urandom_range(30, 120);
      if ($urandom_range(0, 4) == 0) begin
        // sender holds off mid-stream until the block has drained
        for (k = 0; k < n / 2; k++) push_frame(rand_frame());
        settle();
        for (k = n / 2; k < n; k++) push_frame(rand_frame());
      end else begin
        for (k = 0; k < n; k++) push_frame(rand_frame());
      end
      sent += n;
    end

    // --- end of waveform: two more chunks, the second flagged last, then all dropped ---
    settle();
    in_gap_max  = 2;
    out_gap_max = 2;
    write_reg(CFG_CHANNEL_COUNT, 24'd4);
    write_reg(CFG_FRAMES_PER_CHUNK, 24'd3);
    write_reg(CFG_CHUNK_COUNT, 24'(env_chunk + 13'd2));
    for (k = 0; k < 12; k++) push_frame(rand_frame());
    settle();
    // done is sticky: a zero chunk count changes nothing
    write_reg(CFG_CHUNK_COUNT, 24'd0);
    for (k = 0; k < 4; k++) push_frame(rand_frame());
    settle();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
